/* sv/rmm_pkg.sv */
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants for the ratio and mutual match filter.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int IDX_W   = 16;
  localparam int DIST_W  = 24;
  localparam int RATIO_W = 16;
  localparam int RATIO_FRAC = 14;
  localparam int CNT_W   = 2;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd10650;
  localparam int DEFAULT_REVERSE_DEPTH = 256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  query_index;
    logic [IDX_W-1:0]  train_index;
    logic [DIST_W-1:0] nearest;
    logic              ok;
    logic              last;
  } rmm_cmd_t;

  // One reverse table entry.
  typedef struct packed {
    logic [IDX_W-1:0] query_index;
    logic [IDX_W-1:0] train_index;
    logic             valid;
  } rmm_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_EMIT
  } rmm_back_state_t;

endpackage

/* sv/rmm_front.sv */
// ----------------------------------------------------------------------------
// rmm_front
// Accepts requests, holds the ratio limit and applies the ratio test.
// ----------------------------------------------------------------------------
module rmm_front import rmm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RATIO_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [IDX_W-1:0]   query_index,
  input  logic [IDX_W-1:0]   train_index,
  input  logic [DIST_W-1:0]  nearest_distance,
  input  logic [DIST_W-1:0]  second_distance,
  input  logic [CNT_W-1:0]   neighbour_count,
  input  logic               last,
  input  logic               queue_full,
  output logic               push,
  output rmm_cmd_t           cmd
);

  localparam int PROD_W = RATIO_W + DIST_W;

  logic [RATIO_W-1:0] ratio_threshold;
  logic [PROD_W-1:0]  limit;
  logic [PROD_W-1:0]  scaled;
  logic               ratio_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_threshold <= RATIO_RESET;
    end else if (cfg_we) begin
      ratio_threshold <= cfg_wdata;
    end
  end

  // The entry fails when nearest * 2^14 exceeds threshold * second.
  assign limit    = PROD_W'(ratio_threshold) * PROD_W'(second_distance);
  assign scaled   = PROD_W'({nearest_distance, RATIO_FRAC'(0)});
  // A count of two or three means both neighbours are present.
  assign ratio_ok = neighbour_count[1] && !(scaled > limit);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    cmd.op          = operation;
    cmd.query_index = query_index;
    cmd.train_index = train_index;
    cmd.nearest     = nearest_distance;
    cmd.ok          = ratio_ok;
    cmd.last        = last;
  end

endmodule

/* sv/rmm_queue.sv */
// ----------------------------------------------------------------------------
// rmm_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rmm_queue import rmm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rmm_cmd_t push_cmd,
  input  logic     pop,
  output rmm_cmd_t head,
  output logic     full,
  output logic     avail
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = PTR_W + 1;

  rmm_cmd_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_QW-1:0]  count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/rmm_back.sv */
// ----------------------------------------------------------------------------
// rmm_back
// Reverse table, symmetry search and result register.
// ----------------------------------------------------------------------------
module rmm_back import rmm_pkg::*; #(
  parameter int REVERSE_DEPTH = DEFAULT_REVERSE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  rmm_cmd_t          cmd,
  input  logic              cmd_avail,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              matched,
  output logic [IDX_W-1:0]  out_query_index,
  output logic [IDX_W-1:0]  out_train_index,
  output logic [DIST_W-1:0] out_distance,
  output logic              table_overflow,
  output logic              batch_end
);

  localparam int AW = (REVERSE_DEPTH > 1) ? $clog2(REVERSE_DEPTH) : 1;
  localparam int FW = AW + 1;

  rmm_back_state_t state, state_next;

  rmm_entry_t      mem [REVERSE_DEPTH];
  rmm_entry_t      rdata;
  rmm_entry_t      wentry;
  rmm_cmd_t        cur;
  logic [FW-1:0]   fill;
  logic [FW-1:0]   idx;
  logic            overflow_seen;
  logic            rd_pend;
  logic            hit;
  logic            hit_now;
  logic            full;
  logic            out_free;
  logic            mem_we;
  logic            ovf_set;
  logic            capture;
  logic            issue;
  logic            out_load;

  assign full     = (fill == FW'(REVERSE_DEPTH));
  assign out_free = !out_valid || !out_stall;
  // A table entry matches when its indices are the swapped forward indices.
  assign hit_now  = rd_pend && rdata.valid && (rdata.train_index == cur.query_index)
                    && (rdata.query_index == cur.train_index);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_avail && cmd.op == OP_CHECK) begin
          state_next = (cmd.ok && fill != '0) ? B_SEARCH : B_EMIT;
        end
      end
      B_SEARCH: begin
        if (hit_now || (idx == fill && !rd_pend)) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && cmd_avail;
    mem_we   = pop && (cmd.op == OP_LOAD) && !full;
    ovf_set  = pop && (cmd.op == OP_LOAD) && full;
    capture  = pop && (cmd.op == OP_CHECK);
    issue    = (state == B_SEARCH) && (idx < fill);
    out_load = (state == B_EMIT) && out_free;
  end

  always_comb begin
    wentry.query_index = cmd.query_index;
    wentry.train_index = cmd.train_index;
    wentry.valid       = cmd.ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill[AW-1:0]] <= wentry;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      fill          <= '0;
      overflow_seen <= 1'b0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (out_load && cur.last) begin
        fill          <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (mem_we) begin
          fill <= fill + 1'b1;
        end
        if (ovf_set) begin
          overflow_seen <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cur <= cmd;
      idx <= '0;
      hit <= 1'b0;
    end else begin
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (state == B_SEARCH && hit_now) begin
        hit <= 1'b1;
      end
    end
    if (out_load) begin
      matched         <= hit;
      out_query_index <= cur.query_index;
      out_train_index <= cur.train_index;
      out_distance    <= cur.nearest;
      table_overflow  <= overflow_seen;
      batch_end       <= cur.last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(REVERSE_DEPTH))
    else $error("reverse fill count beyond table depth");

  a_search_needs_entries: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEARCH) |-> (cur.ok && fill != '0))
    else $error("search started without a passing entry or a loaded table");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (out_load && cur.last) |=> (fill == '0 && !overflow_seen))
    else $error("table not cleared after the end of a batch");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule

/* sv/ratio_and_mutual_match_filter_unit.sv */
// ----------------------------------------------------------------------------
// ratio_and_mutual_match_filter_unit
// Ratio test and mutual cross check over two-nearest-neighbour matches.
// ----------------------------------------------------------------------------
// Reverse entries (operation 0) are loaded into a table of REVERSE_DEPTH
// entries; loads past capacity are dropped and reported through
// table_overflow. A forward entry (operation 1) gives one result: it goes
// straight to the result register when it fails the ratio test or the table
// is empty, and otherwise it first searches the loaded entries, walking the
// table through its single read port one entry per cycle and stopping at the
// first swapped match or after the last loaded entry. A queue
// of four requests lets the input keep flowing while a search runs, and the
// result register lets the next request proceed while a result waits. The
// forward entry with last set clears the table once its result is issued.
module ratio_and_mutual_match_filter_unit import rmm_pkg::*; #(
  parameter int REVERSE_DEPTH = DEFAULT_REVERSE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RATIO_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [IDX_W-1:0]   query_index,
  input  logic [IDX_W-1:0]   train_index,
  input  logic [DIST_W-1:0]  nearest_distance,
  input  logic [DIST_W-1:0]  second_distance,
  input  logic [CNT_W-1:0]   neighbour_count,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               matched,
  output logic [IDX_W-1:0]   out_query_index,
  output logic [IDX_W-1:0]   out_train_index,
  output logic [DIST_W-1:0]  out_distance,
  output logic               table_overflow,
  output logic               batch_end
);

  rmm_cmd_t push_cmd;
  rmm_cmd_t head;
  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_avail;

  rmm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .query_index      (query_index),
    .train_index      (train_index),
    .nearest_distance (nearest_distance),
    .second_distance  (second_distance),
    .neighbour_count  (neighbour_count),
    .last             (last),
    .queue_full       (queue_full),
    .push             (push),
    .cmd              (push_cmd)
  );

  rmm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (queue_full),
    .avail    (queue_avail)
  );

  rmm_back #(
    .REVERSE_DEPTH (REVERSE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd             (head),
    .cmd_avail       (queue_avail),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .matched         (matched),
    .out_query_index (out_query_index),
    .out_train_index (out_train_index),
    .out_distance    (out_distance),
    .table_overflow  (table_overflow),
    .batch_end       (batch_end)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ratio and mutual match filter. Requests stream
// through a driver that idles at random. Each accepted request updates a
// behavioral copy of the reverse table, and every check request queues the
// result it should give. A monitor compares each accepted result field by
// field. Loads come before checks in batches, with a few stray loads among
// the checks. The threshold is changed between phases while the block is
// idle. A few batches fill the table past capacity to exercise overflow.
// ----------------------------------------------------------------------------
module tb;
  import rmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEFAULT_REVERSE_DEPTH;
  localparam int LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  q;
    logic [IDX_W-1:0]  t;
    logic [DIST_W-1:0] nearest;
    logic [DIST_W-1:0] second;
    logic [CNT_W-1:0]  count;
    logic              last;
  } match_req_t;

  typedef struct {
    logic              matched;
    logic [IDX_W-1:0]  q;
    logic [IDX_W-1:0]  t;
    logic [DIST_W-1:0] distance;
    logic              ovf;
    logic              batch_end;
  } match_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_LOAD;
  logic [IDX_W-1:0] query_index = '0;
  logic [IDX_W-1:0] train_index = '0;
  logic [DIST_W-1:0] nearest_distance = '0;
  logic [DIST_W-1:0] second_distance = '0;
  logic [CNT_W-1:0] neighbour_count = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic matched;
  logic [IDX_W-1:0] out_query_index;
  logic [IDX_W-1:0] out_train_index;
  logic [DIST_W-1:0] out_distance;
  logic table_overflow;
  logic batch_end;

  match_req_t pending_requests[$];
  match_res_t awaited_results[$];
  match_req_t on_wire;

  // Behavioral copy of the block's state.
  logic [RATIO_W-1:0] ratio_now = RATIO_RESET;
  logic [IDX_W-1:0] rev_query[DEPTH];
  logic [IDX_W-1:0] rev_train[DEPTH];
  logic rev_valid[DEPTH] = '{default: 1'b0};
  int rev_fill = 0;
  logic ovf_seen = 1'b0;

  int unsigned cyc = 0;
  int errors = 0;
  int queued = 0;
  int n_loads = 0;
  int n_checks = 0;
  int results_seen = 0;
  int hits = 0;
  int ovf_results = 0;
  int settings = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic calm;

  ratio_and_mutual_match_filter_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .query_index(query_index),
    .train_index(train_index),
    .nearest_distance(nearest_distance),
    .second_distance(second_distance),
    .neighbour_count(neighbour_count),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .matched(matched),
    .out_query_index(out_query_index),
    .out_train_index(out_train_index),
    .out_distance(out_distance),
    .table_overflow(table_overflow),
    .batch_end(batch_end)
  );

  always #5 clk = ~clk;

  // No random idling on either side inside this window.
  assign calm = (cyc >= 3000) && (cyc < 6000);

  function automatic logic ratio_ok(input match_req_t r);
    if (r.count < 2) return 1'b0;
    return !((64'(r.nearest) << RATIO_FRAC) > 64'(ratio_now) * 64'(r.second));
  endfunction

  task automatic filter_predict(input match_req_t r);
    logic ok;
    match_res_t res;
    ok = ratio_ok(r);
    if (r.op == OP_LOAD) begin
      n_loads++;
      if (rev_fill >= DEPTH) begin
        ovf_seen = 1'b1;
      end else begin
        rev_query[rev_fill] = r.q;
        rev_train[rev_fill] = r.t;
        rev_valid[rev_fill] = ok;
        rev_fill++;
      end
    end else begin
      n_checks++;
      res.matched = 1'b0;
      if (ok) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (rev_valid[i] && rev_train[i] == r.q && rev_query[i] == r.t) res.matched = 1'b1;
        end
      end
      res.q = r.q;
      res.t = r.t;
      res.distance = r.nearest;
      res.ovf = ovf_seen;
      res.batch_end = r.last;
      if (res.matched) hits++;
      if (res.ovf) ovf_results++;
      awaited_results = {awaited_results, res};
      if (r.last) begin
        foreach (rev_valid[i]) rev_valid[i] = 1'b0;
        rev_fill = 0;
        ovf_seen = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cyc,
               awaited_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin : drive
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_predict(on_wire);
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          on_wire = pending_requests.pop_front();
          operation <= on_wire.op;
          query_index <= on_wire.q;
          train_index <= on_wire.t;
          nearest_distance <= on_wire.nearest;
          second_distance <= on_wire.second;
          neighbour_count <= on_wire.count;
          last <= on_wire.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_diff(input string field, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Result monitor and receiver stall.
  always @(posedge clk) begin : watch
    match_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual q=%0h t=%0h", $time,
                   out_query_index, out_train_index);
        end else begin
          want = awaited_results.pop_front();
          if (matched !== want.matched)
            report_diff("matched", 32'(want.matched), 32'(matched));
          if (out_query_index !== want.q)
            report_diff("out_query_index", 32'(want.q), 32'(out_query_index));
          if (out_train_index !== want.t)
            report_diff("out_train_index", 32'(want.t), 32'(out_train_index));
          if (out_distance !== want.distance)
            report_diff("out_distance", 32'(want.distance), 32'(out_distance));
          if (table_overflow !== want.ovf)
            report_diff("table_overflow", 32'(want.ovf), 32'(table_overflow));
          if (batch_end !== want.batch_end)
            report_diff("batch_end", 32'(want.batch_end), 32'(batch_end));
        end
      end
      // One long hold-off so that the request queue fills and stalls the input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 100) begin
        hold_left <= 400;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
    end
  end

  task automatic queue_request(input logic op, input logic [IDX_W-1:0] q, input logic [IDX_W-1:0] t,
                               input logic [DIST_W-1:0] n, input logic [DIST_W-1:0] s,
                               input logic [CNT_W-1:0] c, input logic l);
    match_req_t r;
    r.op = op;
    r.q = q;
    r.t = t;
    r.nearest = n;
    r.second = s;
    r.count = c;
    r.last = l;
    pending_requests = {pending_requests, r};
    queued++;
  endtask

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(0, 9) < 8) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 2'd0;
    if (pick == 1) return 2'd1;
    if (pick < 7) return 2'd2;
    return 2'd3;
  endfunction

  // Most distances sit right at the threshold so both outcomes of the ratio
  // test are common under every setting.
  task automatic pick_dist(output logic [DIST_W-1:0] n, output logic [DIST_W-1:0] s);
    int mode;
    longint v;
    mode = $urandom_range(0, 9);
    s = DIST_W'($urandom() >> $urandom_range(8, 31));
    if (mode < 6) begin
      v = longint'((64'(s) * 64'(ratio_now)) >> RATIO_FRAC) + longint'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      n = v[DIST_W-1:0];
    end else if (mode < 8) begin
      n = DIST_W'($urandom());
      s = DIST_W'($urandom());
    end else if (mode == 8) begin
      s = '0;
      n = $urandom_range(0, 1) ? '0 : DIST_W'($urandom_range(1, 1000));
    end else begin
      n = '0;
    end
  endtask

  task automatic add_batch(input int loads, input int checks);
    logic [IDX_W-1:0] pq[$];
    logic [IDX_W-1:0] pt[$];
    logic [IDX_W-1:0] q, t;
    logic [DIST_W-1:0] n, s;
    int k;
    for (int i = 0; i < loads + checks; i++) begin
      // A stray load now and then among the checks.
      if (i < loads || $urandom_range(0, 9) == 0) begin
        q = rand_index();
        t = rand_index();
        pick_dist(n, s);
        queue_request(OP_LOAD, q, t, n, s, rand_count(), $urandom_range(0, 19) == 0);
        pq = {pq, q};
        pt = {pt, t};
      end
      if (i >= loads) begin
        if (pq.size() != 0 && $urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, pq.size() - 1);
          q = pt[k];
          t = pq[k];
        end else begin
          q = rand_index();
          t = rand_index();
        end
        pick_dist(n, s);
        queue_request(OP_CHECK, q, t, n, s, rand_count(), i == loads + checks - 1);
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ratio(input logic [RATIO_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ratio_now = value;
    settings++;
  endtask

  initial begin : main
    logic [RATIO_W-1:0] ratios[6];
    int start;
    ratios = '{16'd16384, 16'd0, 16'hFFFF, 16'd8192, 16'd0, 16'd10650};
    ratios[4] = RATIO_W'($urandom_range(0, 65535));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed batch at the reset threshold.
    queue_request(OP_LOAD, 16'd5, 16'd7, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_LOAD, 16'd8, 16'd9, 24'd100, 24'd200, 2'd1, 1'b0);
    queue_request(OP_LOAD, 16'd10, 16'd11, 24'd0, 24'd0, 2'd0, 1'b0);
    queue_request(OP_LOAD, 16'd12, 16'd13, 24'd100, 24'd200, 2'd3, 1'b0);
    queue_request(OP_LOAD, 16'd14, 16'd15, 24'd0, 24'd0, 2'd2, 1'b0);
    queue_request(OP_LOAD, 16'd16, 16'd17, 24'd1, 24'd0, 2'd2, 1'b0);
    queue_request(OP_LOAD, 16'hFFFF, 16'd0, 24'd0, 24'hFFFFFF, 2'd2, 1'b0);
    queue_request(OP_LOAD, 16'd0, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 2'd2, 1'b0);
    // Exactly at the threshold passes; the last marker on a load is ignored.
    queue_request(OP_LOAD, 16'd20, 16'd21, 24'd10650, 24'd16384, 2'd2, 1'b1);
    queue_request(OP_LOAD, 16'd22, 16'd23, 24'd10651, 24'd16384, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd7, 16'd5, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd9, 16'd8, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd11, 16'd10, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd13, 16'd12, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd15, 16'd14, 24'd0, 24'd0, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd17, 16'd16, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd0, 16'hFFFF, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'hFFFF, 16'd0, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd21, 16'd20, 24'd10650, 24'd16384, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd23, 16'd22, 24'd100, 24'd200, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd7, 16'd5, 24'd1, 24'd0, 2'd2, 1'b0);
    queue_request(OP_CHECK, 16'd7, 16'd5, 24'hFFFFFF, 24'hFFFFFF, 2'd3, 1'b1);
    // The table is empty again after the end of the batch.
    queue_request(OP_CHECK, 16'd7, 16'd5, 24'd100, 24'd200, 2'd2, 1'b1);

    foreach (ratios[p]) begin
      wait_quiet();
      set_ratio(ratios[p]);
      start = queued;
      if (p == 2 || p == 4) add_batch(DEPTH + $urandom_range(1, 20), 6);
      while (queued - start < PHASE_ITEMS)
        add_batch($urandom_range(0, 12), $urandom_range(1, 12));
    end
    wait_quiet();

    $display("Sent %0d loads and %0d checks under %0d threshold settings.", n_loads, n_checks,
             settings);
    $display("Checked %0d results: %0d symmetric, %0d with table overflow, %0d errors.",
             results_seen, hits, ovf_results, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
